// File: hdl/rgbds_pkg.sv
`timescale 1ns / 1ps

package rgbds_pkg;

    localparam int PIX_W    = 16;
    localparam int GRAY_W   = 7;
    localparam int COORD_W  = 7;
    localparam int GRAY_MAX = 125;

    localparam logic [PIX_W-1:0] RED_MASK   = 16'b1111100000000000;
    localparam logic [PIX_W-1:0] GREEN_MASK = 16'b0000011111100000;
    localparam logic [PIX_W-1:0] BLUE_MASK  = 16'b0000000000011111;

    typedef struct packed {
        logic evt;
        logic add;
        logic emit;
        logic last;
    } ctl_t;

    function automatic logic [GRAY_W-1:0] gray_of(input logic [PIX_W-1:0] w);
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        red   = (w & RED_MASK) >> 11;
        green = (w & GREEN_MASK) >> 5;
        blue  = w & BLUE_MASK;
        return GRAY_W'(red) + GRAY_W'(green) + GRAY_W'(blue);
    endfunction

endpackage

// File: hdl/rgbds_ram.sv
`timescale 1ns / 1ps

module rgbds_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/rgbds_acc.sv
`timescale 1ns / 1ps

module rgbds_acc #(
    parameter int IN_WIDTH  = 320,
    parameter int IN_HEIGHT = 240,
    parameter int OUT_SIZE  = 96,
    localparam int RF      = IN_HEIGHT / OUT_SIZE,
    localparam int CF      = IN_WIDTH / OUT_SIZE,
    localparam int RF_S    = (RF > 0) ? RF : 1,
    localparam int CF_S    = (CF > 0) ? CF : 1,
    localparam int OC_W    = $clog2(OUT_SIZE),
    localparam int PSUM_W  = $clog2(CF_S * rgbds_pkg::GRAY_MAX + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [rgbds_pkg::PIX_W-1:0]  pixel_word,
    input  logic                         frame_start,
    output rgbds_pkg::ctl_t              ctl,
    output logic [OC_W-1:0]              oc,
    output logic [OC_W-1:0]              orow,
    output logic [PSUM_W-1:0]            psum
);

    localparam bit ENABLE  = (RF > 0) && (CF > 0);
    localparam int ROW_LIM = OUT_SIZE * RF;
    localparam int COL_LIM = OUT_SIZE * CF;
    localparam int ROW_W   = $clog2(IN_HEIGHT);
    localparam int COL_W   = $clog2(IN_WIDTH);
    localparam int RPH_W   = (RF_S > 1) ? $clog2(RF_S) : 1;
    localparam int CPH_W   = (CF_S > 1) ? $clog2(CF_S) : 1;

    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [RPH_W-1:0]  rph_reg,  rph_next;
    logic [CPH_W-1:0]  cph_reg,  cph_next;
    logic [OC_W-1:0]   orow_reg, orow_next;
    logic [OC_W-1:0]   oc_reg,   oc_next;
    logic [PSUM_W-1:0] psum_reg, psum_next;

    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    logic [RPH_W-1:0]  rph;
    logic [CPH_W-1:0]  cph;
    logic [OC_W-1:0]   orow_b;
    logic [OC_W-1:0]   oc_b;
    logic [PSUM_W-1:0] psum_b;
    logic [PSUM_W-1:0] psum_add;
    logic              row_in;
    logic              col_in;
    logic              col_last;

    always_comb
    begin
        r        = frame_start ? '0 : row_reg;
        c        = frame_start ? '0 : col_reg;
        rph      = frame_start ? '0 : rph_reg;
        cph      = frame_start ? '0 : cph_reg;
        orow_b   = frame_start ? '0 : orow_reg;
        oc_b     = frame_start ? '0 : oc_reg;
        psum_b   = frame_start ? '0 : psum_reg;
        psum_add = psum_b + PSUM_W'(rgbds_pkg::gray_of(pixel_word));
        row_in   = 32'(r) < 32'(ROW_LIM);
        col_in   = 32'(c) < 32'(COL_LIM);
        col_last = cph == CPH_W'(CF_S - 1);

        ctl.evt  = ENABLE && row_in && col_in && col_last;
        ctl.add  = rph != '0;
        ctl.emit = rph == RPH_W'(RF_S - 1);
        ctl.last = (orow_b == OC_W'(OUT_SIZE - 1)) && (oc_b == OC_W'(OUT_SIZE - 1));
        oc       = oc_b;
        orow     = orow_b;
        psum     = psum_add;
    end

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        rph_next  = rph_reg;
        cph_next  = cph_reg;
        orow_next = orow_reg;
        oc_next   = oc_reg;
        psum_next = psum_reg;
        if (take)
        begin
            if (ENABLE && row_in && col_in)
            begin
                psum_next = col_last ? '0 : psum_add;
            end
            else
            begin
                psum_next = psum_b;
            end

            if (c == COL_W'(IN_WIDTH - 1))
            begin
                col_next = '0;
                cph_next = '0;
                oc_next  = '0;
                if (r == ROW_W'(IN_HEIGHT - 1))
                begin
                    row_next  = '0;
                    rph_next  = '0;
                    orow_next = '0;
                end
                else
                begin
                    row_next  = r + 1'b1;
                    rph_next  = rph;
                    orow_next = orow_b;
                    if (row_in)
                    begin
                        if (rph == RPH_W'(RF_S - 1))
                        begin
                            rph_next  = '0;
                            orow_next = (orow_b == OC_W'(OUT_SIZE - 1)) ? '0 : orow_b + 1'b1;
                        end
                        else
                        begin
                            rph_next = rph + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                col_next  = c + 1'b1;
                row_next  = r;
                rph_next  = rph;
                orow_next = orow_b;
                cph_next  = cph;
                oc_next   = oc_b;
                if (col_in)
                begin
                    if (col_last)
                    begin
                        cph_next = '0;
                        oc_next  = (oc_b == OC_W'(OUT_SIZE - 1)) ? '0 : oc_b + 1'b1;
                    end
                    else
                    begin
                        cph_next = cph + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            rph_reg  <= '0;
            cph_reg  <= '0;
            orow_reg <= '0;
            oc_reg   <= '0;
            psum_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            rph_reg  <= rph_next;
            cph_reg  <= cph_next;
            orow_reg <= orow_next;
            oc_reg   <= oc_next;
            psum_reg <= psum_next;
        end
    end

endmodule

// File: hdl/rgbds_div.sv
`timescale 1ns / 1ps

module rgbds_div #(
    parameter int DIVISOR = 6,
    parameter int TOT_W   = 10,
    parameter int OC_W    = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [TOT_W-1:0]               total,
    input  logic [OC_W-1:0]                row,
    input  logic [OC_W-1:0]                col,
    input  logic                           last,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [rgbds_pkg::GRAY_W-1:0]   out_value,
    output logic [rgbds_pkg::COORD_W-1:0]  out_row,
    output logic [rgbds_pkg::COORD_W-1:0]  out_col,
    output logic                           last_of_frame
);

    localparam int DIV_L  = $clog2(DIVISOR);
    localparam int SHIFT  = TOT_W + DIV_L;
    localparam int PROD_W = 2 * TOT_W + 1;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

    logic                           s2_valid_reg, s2_valid_next;
    logic [TOT_W-1:0]               s2_total_reg;
    logic [OC_W-1:0]                s2_row_reg;
    logic [OC_W-1:0]                s2_col_reg;
    logic                           s2_last_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [rgbds_pkg::GRAY_W-1:0]   out_value_reg;
    logic [rgbds_pkg::COORD_W-1:0]  out_row_reg;
    logic [rgbds_pkg::COORD_W-1:0]  out_col_reg;
    logic                           out_last_reg;

    logic                           out_ready;
    logic                           s2_ready;
    logic [PROD_W-1:0]              prod;

    assign out_ready = !out_valid_reg || !result_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign in_ready  = s2_ready;
    assign prod      = PROD_W'(s2_total_reg) * PROD_W'(RECIP);

    always_comb
    begin
        s2_valid_next  = s2_ready ? in_valid : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && in_valid)
        begin
            s2_total_reg <= total;
            s2_row_reg   <= row;
            s2_col_reg   <= col;
            s2_last_reg  <= last;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_value_reg <= rgbds_pkg::GRAY_W'(prod >> SHIFT);
            out_row_reg   <= rgbds_pkg::COORD_W'(s2_row_reg);
            out_col_reg   <= rgbds_pkg::COORD_W'(s2_col_reg);
            out_last_reg  <= s2_last_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign last_of_frame = out_last_reg;

endmodule

// File: hdl/rgb565_gray_box_downscaler.sv
`timescale 1ns / 1ps
// RGB565 to gray box downscaler.
// Pixel channel: pixel_valid / pixel_stall carry pixel_word and frame_start in
// raster order; a transfer happens on a rising edge with valid high, stall low.
// Each pixel becomes gray = R5 + G6 + B5 and is summed over windows of
// IN_HEIGHT/OUT_SIZE rows by IN_WIDTH/OUT_SIZE columns (2 x 3 by default).
// Per output column the sum of the earlier window rows lives in a one-port-
// write, one-port-read RAM of OUT_SIZE entries; the last pixel of each window
// row reads it, except in the window's first row, and writes it, except in its last.
// Result channel: result_valid / result_stall carry out_value (window average,
// truncated), out_row, out_col and last_of_frame. One transfer per window, on
// its bottom-right pixel; no result for pixels outside the windows.
// Throughput: one pixel per clock while pixel_stall is low. The result goes
// from the window's last pixel through the RAM read, the add into the total
// register and the reciprocal multiply into the output register.
// Reset clears the position counters, the running sum and all valid flags; the
// RAM is not cleared, each entry is written before it is read.
// When result_stall is held the output register holds its value, the pipeline
// fills and then pixel_stall rises; no pixel is lost.

module rgb565_gray_box_downscaler #(
    parameter int IN_WIDTH  = 320,
    parameter int IN_HEIGHT = 240,
    parameter int OUT_SIZE  = 96
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [rgbds_pkg::PIX_W-1:0]     pixel_word,
    input  logic                            frame_start,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [rgbds_pkg::GRAY_W-1:0]    out_value,
    output logic [rgbds_pkg::COORD_W-1:0]   out_row,
    output logic [rgbds_pkg::COORD_W-1:0]   out_col,
    output logic                            last_of_frame
);

    localparam int RF        = IN_HEIGHT / OUT_SIZE;
    localparam int CF        = IN_WIDTH / OUT_SIZE;
    localparam int RF_S      = (RF > 0) ? RF : 1;
    localparam int CF_S      = (CF > 0) ? CF : 1;
    localparam int DIVISOR   = RF_S * CF_S;
    localparam int OC_W      = $clog2(OUT_SIZE);
    localparam int PSUM_W    = $clog2(CF_S * rgbds_pkg::GRAY_MAX + 1);
    localparam int STORE_MAX = (RF_S - 1) * CF_S * rgbds_pkg::GRAY_MAX;
    localparam int STORE_W   = (STORE_MAX > 0) ? $clog2(STORE_MAX + 1) : 1;
    localparam int TOT_W     = $clog2(DIVISOR * rgbds_pkg::GRAY_MAX + 1);

    rgbds_pkg::ctl_t     ctl;
    logic [OC_W-1:0]     acc_oc;
    logic [OC_W-1:0]     acc_orow;
    logic [PSUM_W-1:0]   acc_psum;
    logic                pixel_take;

    logic                s1_valid_reg, s1_valid_next;
    logic [PSUM_W-1:0]   s1_psum_reg;
    logic                s1_add_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic [OC_W-1:0]     s1_oc_reg;
    logic [OC_W-1:0]     s1_orow_reg;
    logic                s1_fwd_reg;
    logic [STORE_W-1:0]  s1_fwd_data_reg;

    logic                s1_adv;
    logic                div_ready;
    logic                rd_en;
    logic [STORE_W-1:0]  rd_data;
    logic                wr_en;
    logic [STORE_W-1:0]  wr_data;
    logic [STORE_W-1:0]  stored;
    logic [TOT_W-1:0]    total;

    assign s1_adv      = !s1_emit_reg || div_ready;
    assign pixel_stall = s1_valid_reg && !s1_adv;
    assign pixel_take  = pixel_valid && !pixel_stall;

    rgbds_acc #(
        .IN_WIDTH  (IN_WIDTH),
        .IN_HEIGHT (IN_HEIGHT),
        .OUT_SIZE  (OUT_SIZE)
    ) u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (pixel_take),
        .pixel_word  (pixel_word),
        .frame_start (frame_start),
        .ctl         (ctl),
        .oc          (acc_oc),
        .orow        (acc_orow),
        .psum        (acc_psum)
    );

    assign rd_en   = pixel_take && ctl.evt && ctl.add;
    assign wr_en   = s1_valid_reg && !s1_emit_reg;
    assign stored  = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
    assign total   = TOT_W'(s1_psum_reg) + (s1_add_reg ? TOT_W'(stored) : '0);
    assign wr_data = STORE_W'(total);

    rgbds_ram #(
        .WIDTH (STORE_W),
        .DEPTH (OUT_SIZE)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_oc_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (acc_oc),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (pixel_take)
        begin
            s1_valid_next = ctl.evt;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // forward a same-entry write that lands with the read
    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            s1_psum_reg     <= acc_psum;
            s1_add_reg      <= ctl.add;
            s1_emit_reg     <= ctl.emit;
            s1_last_reg     <= ctl.last;
            s1_oc_reg       <= acc_oc;
            s1_orow_reg     <= acc_orow;
            s1_fwd_reg      <= wr_en && (s1_oc_reg == acc_oc);
            s1_fwd_data_reg <= wr_data;
        end
    end

    rgbds_div #(
        .DIVISOR (DIVISOR),
        .TOT_W   (TOT_W),
        .OC_W    (OC_W)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s1_valid_reg && s1_emit_reg),
        .in_ready      (div_ready),
        .total         (total),
        .row           (s1_orow_reg),
        .col           (s1_oc_reg),
        .last          (s1_last_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_frame (last_of_frame)
    );

endmodule
